/* rtl/core/u2e_pkg.sv */
package u2e_pkg;

  // input item kinds carried on s_tuser
  typedef enum logic [1:0] {
    FUNC_UNIT = 2'd0,
    FUNC_SEP  = 2'd1,
    FUNC_EOM  = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  // case forcing register codes (signed, any negative value means lower)
  localparam logic [1:0] CASE_KEEP  = 2'b00;
  localparam logic [1:0] CASE_UPPER = 2'b01;

  // characters used by escaping and framing
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // surrogate tags in the top six bits of a code unit
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

  // plane offset added to the high surrogate bits (0x10000 >> 10)
  localparam logic [10:0] PLANE_OFFSET = 11'd64;

  // one decoded item: up to four bytes, first byte may be an error beat
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            err0;
  } job_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

/* rtl/core/u2e_front.sv */
module u2e_front import u2e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] code_unit
  input  logic [1:0]  s_tuser,   // [1:0] func
  input  logic        q_full,
  output logic        push,
  output job_t        push_job
);

  logic [1:0] case_mode;
  logic [9:0] held_high_bits;
  logic       high_pending;
  logic       field_open;

  logic [9:0] held_high_bits_next;
  logic       high_pending_next;
  logic       field_open_next;

  logic       accept;
  logic       has_job;
  job_t       job;
  func_t      func;
  logic [15:0] u;
  logic        is_high;
  logic        is_low;
  logic [6:0]  c_forced;
  logic [20:0] cp;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign func      = func_t'(s_tuser);
  assign u         = s_tdata;
  assign is_high   = (u[15:10] == SURR_HIGH_TAG);
  assign is_low    = (u[15:10] == SURR_LOW_TAG);
  assign cp        = {({1'b0, held_high_bits} + PLANE_OFFSET), u[9:0]};

  // ascii case forcing
  always_comb begin
    c_forced = u[6:0];
    if (case_mode == CASE_UPPER) begin
      if (u[6:0] >= 7'h61 && u[6:0] <= 7'h7A) c_forced = {u[6], 1'b0, u[4:0]};
    end else if (case_mode[1]) begin
      if (u[6:0] >= 7'h41 && u[6:0] <= 7'h5A) c_forced = {u[6], 1'b1, u[4:0]};
    end
  end

  // classify the item and build its byte job
  always_comb begin
    job                 = '0;
    has_job             = 1'b0;
    held_high_bits_next = held_high_bits;
    high_pending_next   = high_pending;
    field_open_next     = field_open;
    unique case (func)
      FUNC_UNIT: begin
        if (high_pending) begin
          has_job             = 1'b1;
          high_pending_next   = 1'b0;
          held_high_bits_next = '0;
          if (is_low) begin
            job.bytes[0] = {5'b11110, cp[20:18]};
            job.bytes[1] = {2'b10, cp[17:12]};
            job.bytes[2] = {2'b10, cp[11:6]};
            job.bytes[3] = {2'b10, cp[5:0]};
            job.last_idx = 2'd3;
          end else begin
            job.err0 = 1'b1;
          end
        end else if (is_high) begin
          held_high_bits_next = u[9:0];
          high_pending_next   = 1'b1;
        end else if (u[15:7] == '0) begin
          has_job = 1'b1;
          if (c_forced == '0) begin
            job.bytes[0] = CH_BSLASH;
            job.bytes[1] = CH_ZERO;
            job.last_idx = 2'd1;
          end else if ({1'b0, c_forced} == CH_LPAREN || {1'b0, c_forced} == CH_RPAREN ||
                       {1'b0, c_forced} == CH_COLON || {1'b0, c_forced} == CH_BSLASH ||
                       {1'b0, c_forced} == CH_BAR) begin
            job.bytes[0] = CH_BSLASH;
            job.bytes[1] = {1'b0, c_forced};
            job.last_idx = 2'd1;
          end else begin
            job.bytes[0] = {1'b0, c_forced};
          end
        end else if (u[15:11] == '0) begin
          has_job      = 1'b1;
          job.bytes[0] = {3'b110, u[10:6]};
          job.bytes[1] = {2'b10, u[5:0]};
          job.last_idx = 2'd1;
        end else begin
          has_job      = 1'b1;
          job.bytes[0] = {4'b1110, u[15:12]};
          job.bytes[1] = {2'b10, u[11:6]};
          job.bytes[2] = {2'b10, u[5:0]};
          job.last_idx = 2'd2;
        end
      end
      FUNC_SEP: begin
        field_open_next = 1'b1;
        if (high_pending) begin
          has_job             = 1'b1;
          high_pending_next   = 1'b0;
          held_high_bits_next = '0;
          job.err0            = 1'b1;
          if (field_open) begin
            job.bytes[1] = CH_COLON;
            job.last_idx = 2'd1;
          end
        end else if (field_open) begin
          has_job      = 1'b1;
          job.bytes[0] = CH_COLON;
        end
      end
      FUNC_EOM: begin
        field_open_next = 1'b0;
        has_job         = 1'b1;
        if (high_pending) begin
          high_pending_next   = 1'b0;
          held_high_bits_next = '0;
          job.err0            = 1'b1;
          job.bytes[1]        = CH_BAR;
          job.last_idx        = 2'd1;
        end else begin
          job.bytes[0] = CH_BAR;
        end
      end
      FUNC_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign push     = accept && has_job;
  assign push_job = job;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      case_mode <= CASE_KEEP;
    end else if (cfg_valid && cfg_ready) begin
      case_mode <= cfg_data;
    end
  end

  // surrogate and field state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_high_bits <= '0;
      high_pending   <= 1'b0;
      field_open     <= 1'b0;
    end else if (accept) begin
      held_high_bits <= held_high_bits_next;
      high_pending   <= high_pending_next;
      field_open     <= field_open_next;
    end
  end

  // an error beat always reads as a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    push && push_job.err0 |-> push_job.bytes[0] == '0)
    else $error("error job with nonzero first byte");

endmodule

/* rtl/core/u2e_queue.sv */
module u2e_queue import u2e_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");

endmodule

/* rtl/core/u2e_back.sv */
module u2e_back import u2e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  job_t       head,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // last
  output logic       m_tuser    // [0] error
);

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = !q_empty && (!m_tvalid || m_tready);
  assign at_last = (idx == head.last_idx);
  assign pop     = load && at_last;

  // byte index within the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= at_last ? '0 : idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= head.bytes[idx];
      m_tlast <= at_last;
      m_tuser <= head.err0 && (idx == '0);
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx <= head.last_idx)
    else $error("byte index past end of job");
  a_err_beat_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error beat with nonzero byte");
  a_idx_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == '0)
    else $error("byte index not restarted after job");

endmodule

/* rtl/core/utf16_to_escaped_utf8_framer_core.sv */
// channel  | direction | payload                                   | handshake
// s_*      | in        | tdata[15:0] code_unit, tuser[1:0] func    | tvalid/tready
// m_*      | out       | tdata[7:0] out_byte, tlast last, tuser err | tvalid/tready
// cfg_*    | in        | cfg_data[1:0] case_mode                   | cfg_valid/cfg_ready
//
// an item is taken whenever the two-entry job queue has room
// output side sends one byte per cycle unless stalled; an item gives 0-4 bytes
// an accepted item is registered in the queue first, then its first byte in
// the output register, when the queue and output side are idle
// reset is synchronous; surrogate and field state clear, case_mode returns to 0
// output stalls back up through the queue; s_tready drops only while it is full
module utf16_to_escaped_utf8_framer_core import u2e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] code_unit
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // last
  output logic        m_tuser    // [0] error
);

  logic push;
  job_t push_job;
  logic pop;
  job_t head;
  logic q_empty;
  logic q_full;

  // classify items and keep surrogate state
  u2e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // job queue between the two sides
  u2e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // byte serializer
  u2e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
